// File: rtl/mhpq_pkg.sv
package mhpq_pkg;

	localparam int OP_W    = 2;
	localparam int KEY_W   = 32;
	localparam int POS_W   = 9;
	localparam int COUNT_W = 9;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_RM_ROOT,
		S_RM_LAST,
		S_DN_CHK,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_RD_WAIT,
		S_DONE
	} mhpq_state_t;

	// finished result handed from the sequencer to the output stage
	typedef struct packed {
		logic                    ok;
		logic signed [KEY_W-1:0] key;
	} mhpq_res_t;

endpackage

// File: rtl/mhpq_ram.sv
module mhpq_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [mhpq_pkg::KEY_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [mhpq_pkg::KEY_W-1:0]  rdata
);
	import mhpq_pkg::*;

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/mhpq_seq.sv
module mhpq_seq #(
	parameter int CAPACITY = 256,
	parameter int AW       = 8,
	parameter int CW       = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mhpq_pkg::OP_W-1:0]   opcode,
	input  logic [mhpq_pkg::KEY_W-1:0]  key_in,
	input  logic [mhpq_pkg::POS_W-1:0]  position,
	output logic                        idle,
	output logic                        done,
	input  logic                        done_ack,
	output mhpq_pkg::mhpq_res_t         res,
	output logic [CW-1:0]               cnt,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [mhpq_pkg::KEY_W-1:0]  mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [mhpq_pkg::KEY_W-1:0]  mem_rdata
);
	import mhpq_pkg::*;

	localparam int PW = (CW > POS_W) ? CW : POS_W;

	mhpq_state_t state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    pos_q, pos_d;
	logic [AW-1:0]    cidx_q, cidx_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [KEY_W-1:0] cand_q, cand_d;
	logic             ok_q, ok_d;
	logic [KEY_W-1:0] rkey_q, rkey_d;

	// shared signed compare
	logic [KEY_W-1:0] gt_a, gt_b;
	logic             gt;

	logic [PW-1:0] pos_ext, cnt_ext, pos_m1;
	logic [CW:0]   child, child_p1, cnt_w;
	logic [AW-1:0] up_m1, parent;
	logic [CW-1:0] cnt_m1;
	logic          full;

	assign gt = $signed(gt_a) > $signed(gt_b);

	assign pos_ext  = PW'(position);
	assign cnt_ext  = PW'(count_q);
	assign pos_m1   = pos_ext - PW'(1);
	assign child    = (CW+1)'({pos_q, 1'b1});
	assign child_p1 = child + (CW+1)'(1);
	assign cnt_w    = (CW+1)'(count_q);
	assign up_m1    = pos_q - AW'(1);
	assign parent   = up_m1 >> 1;
	assign cnt_m1   = count_q - CW'(1);
	assign full     = (count_q == CW'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		cidx_q <= cidx_d;
		key_q  <= key_d;
		cand_q <= cand_d;
		ok_q   <= ok_d;
		rkey_q <= rkey_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		cidx_d    = cidx_q;
		key_d     = key_q;
		cand_d    = cand_q;
		ok_d      = ok_q;
		rkey_d    = rkey_q;
		gt_a      = key_q;
		gt_b      = mem_rdata;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		done      = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ok_d    = 1'b0;
					rkey_d  = '0;
					state_d = S_DONE;
					unique case (opcode)
						OP_INSERT: begin
							if (!full) begin
								pos_d   = count_q[AW-1:0];
								key_d   = key_in;
								count_d = count_q + CW'(1);
								ok_d    = 1'b1;
								state_d = S_UP_RD;
							end
						end
						OP_REMOVE: begin
							if (count_q != '0) begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								state_d   = S_RM_ROOT;
							end
						end
						OP_READ: begin
							if (pos_ext != '0 && pos_ext <= cnt_ext) begin
								mem_re    = 1'b1;
								mem_raddr = pos_m1[AW-1:0];
								state_d   = S_RD_WAIT;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = parent;
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				gt_a   = key_q;
				gt_b   = mem_rdata;
				mem_we = 1'b1;
				if (gt) begin
					// parent moves down, walk one level up
					mem_wdata = mem_rdata;
					pos_d     = parent;
					state_d   = S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RM_ROOT: begin
				rkey_d    = mem_rdata;
				mem_re    = 1'b1;
				mem_raddr = cnt_m1[AW-1:0];
				state_d   = S_RM_LAST;
			end
			S_RM_LAST: begin
				key_d   = mem_rdata;
				count_d = cnt_m1;
				pos_d   = '0;
				ok_d    = 1'b1;
				state_d = (cnt_m1 == '0) ? S_DONE : S_DN_CHK;
			end
			S_DN_CHK: begin
				if (child >= cnt_w) begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = child[AW-1:0];
					state_d   = S_DN_L;
				end
			end
			S_DN_L: begin
				cand_d = mem_rdata;
				cidx_d = child[AW-1:0];
				if (child_p1 < cnt_w) begin
					mem_re    = 1'b1;
					mem_raddr = child_p1[AW-1:0];
					state_d   = S_DN_R;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_R: begin
				gt_a = mem_rdata;
				gt_b = cand_q;
				if (gt) begin
					cand_d = mem_rdata;
					cidx_d = child_p1[AW-1:0];
				end
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				gt_a   = cand_q;
				gt_b   = key_q;
				mem_we = 1'b1;
				if (gt) begin
					mem_wdata = cand_q;
					pos_d     = cidx_q;
					state_d   = S_DN_CHK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD_WAIT: begin
				rkey_d  = mem_rdata;
				ok_d    = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				done = 1'b1;
				if (done_ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign idle    = (state_q == S_IDLE);
	assign res.ok  = ok_q;
	assign res.key = rkey_q;
	assign cnt     = count_q;

endmodule

// File: rtl/max_heap_priority_queue_unit.sv
// a find reads the addressed entry and hands it on; an insert reads and compares each parent it climbs past,
// a remove-max reads the root and the last entry, then reads and compares the children of each level descended;
// one heap memory read per cycle, each followed by the shared compare, sets the pace
// throughput: one word at a time, the next word is taken once the result is in the output register
// reset: arst_n clears the entry count and sequencer; the heap memory is not cleared
// and needs no clearing pass, since only written entries are ever read
module max_heap_priority_queue_unit #(
	parameter int CAPACITY = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mhpq_pkg::OP_W-1:0]           opcode,
	input  logic signed [mhpq_pkg::KEY_W-1:0]   key_in,
	input  logic [mhpq_pkg::POS_W-1:0]          position,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic signed [mhpq_pkg::KEY_W-1:0]   key_out,
	output logic [mhpq_pkg::COUNT_W-1:0]        count,
	output logic                                is_empty,
	output logic                                is_full
);
	import mhpq_pkg::*;

	// address width of the heap memory, count width holds CAPACITY itself
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic             seq_idle;
	logic             seq_done;
	logic             done_ack;
	mhpq_res_t        seq_res;
	logic [CW-1:0]    seq_cnt;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [KEY_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [KEY_W-1:0] mem_rdata;

	// output register
	logic                  out_valid_q;
	logic                  ok_q;
	logic [KEY_W-1:0]      key_out_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  is_empty_q;
	logic                  is_full_q;
	logic                  load;

	// heap storage, one write and one registered read per cycle
	mhpq_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer: sift up, sift down and find around one shared compare
	mhpq_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.opcode    (opcode),
		.key_in    (key_in),
		.position  (position),
		.idle      (seq_idle),
		.done      (seq_done),
		.done_ack  (done_ack),
		.res       (seq_res),
		.cnt       (seq_cnt),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// the result moves out once the output slot is free or being drained
	assign done_ack = !out_valid_q || out_ready;
	assign load     = seq_done && done_ack;
	assign in_ready = seq_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q       <= seq_res.ok;
			key_out_q  <= seq_res.key;
			count_q    <= COUNT_W'(seq_cnt);
			is_empty_q <= (seq_cnt == '0);
			is_full_q  <= (seq_cnt == CW'(CAPACITY));
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign key_out   = key_out_q;
	assign count     = count_q;
	assign is_empty  = is_empty_q;
	assign is_full   = is_full_q;

	// a taken word keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after accepting a word");

	// the entry count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seq_cnt <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// a result word is never both empty and full
	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("result flags both empty and full");

	// no result is loaded while the sequencer stands idle
	a_done_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> !seq_idle)
		else $error("sequencer done while idle");

endmodule

// File: tb/max_heap_priority_queue_unit_test.sv
module max_heap_priority_queue_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mhpq_pkg::*;

	localparam int CAPACITY = 256;
	// opcode that the block must answer with a plain failure
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	// cycles with no word accepted on either side before the run is abandoned
	localparam int QUIET_LIMIT = 2000;
	// settle time after the last result, longer than the slowest remove-max
	localparam int DRAIN_CYCLES = 60;

	// one word into the block
	typedef struct {
		logic [OP_W-1:0]         opcode;
		logic signed [KEY_W-1:0] key;
		logic [POS_W-1:0]        position;
	} heap_op_t;

	// one word out of the block
	typedef struct {
		logic                    ok;
		logic signed [KEY_W-1:0] key;
		logic [COUNT_W-1:0]      count;
		logic                    is_empty;
		logic                    is_full;
	} heap_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, known from time zero
	logic                    in_valid = 1'b0;
	logic [OP_W-1:0]         opcode = '0;
	logic signed [KEY_W-1:0] key_in = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    out_ready = 1'b0;

	// block outputs
	logic                    in_ready;
	logic                    out_valid;
	logic                    ok;
	logic signed [KEY_W-1:0] key_out;
	logic [COUNT_W-1:0]      count;
	logic                    is_empty;
	logic                    is_full;

	// stimulus waiting for the driver, and results the heap should give back
	heap_op_t     pending_ops[$];
	heap_result_t expected_results[$];
	heap_op_t     driven_op;

	// idling knobs, percent of cycles
	int sender_idle_pct = 0;
	int sink_stall_pct = 0;

	// predicted heap contents and entry count
	logic signed [KEY_W-1:0] heap_model [0:CAPACITY-1];
	int unsigned             heap_fill = 0;

	// entry count as the stimulus generator sees it, to aim positions and targets
	int shadow_fill = 0;

	int mismatch_count = 0;

	max_heap_priority_queue_unit #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.key_in   (key_in),
		.position (position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok       (ok),
		.key_out  (key_out),
		.count    (count),
		.is_empty (is_empty),
		.is_full  (is_full)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// heap predictor: applies one operation to the model, returns the answer
	// ------------------------------------------------------------------
	function automatic heap_result_t apply_heap_op(heap_op_t op);
		heap_result_t            r;
		int unsigned             pos;
		int unsigned             parent;
		int unsigned             child;
		logic signed [KEY_W-1:0] moving;
		bit                      done;
		r.ok = 1'b0;
		r.key = '0;
		case (op.opcode)
			OP_INSERT: begin
				if (heap_fill < CAPACITY) begin
					// new key goes after the last entry and climbs while strictly larger
					pos = heap_fill;
					heap_fill++;
					moving = op.key;
					done = 1'b0;
					while (!done && pos > 0) begin
						parent = (pos - 1) / 2;
						if (moving > heap_model[parent]) begin
							heap_model[pos] = heap_model[parent];
							pos = parent;
						end else begin
							done = 1'b1;
						end
					end
					heap_model[pos] = moving;
					r.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (heap_fill > 0) begin
					r.key = heap_model[0];
					heap_model[0] = heap_model[heap_fill - 1];
					heap_fill--;
					r.ok = 1'b1;
					if (heap_fill > 0) begin
						// last entry sinks from the root; right child only if strictly larger
						moving = heap_model[0];
						pos = 0;
						done = 1'b0;
						while (!done && 2 * pos + 1 < heap_fill) begin
							child = 2 * pos + 1;
							if (child + 1 < heap_fill && heap_model[child + 1] > heap_model[child])
								child++;
							if (heap_model[child] > moving) begin
								heap_model[pos] = heap_model[child];
								pos = child;
							end else begin
								done = 1'b1;
							end
						end
						heap_model[pos] = moving;
					end
				end
			end
			OP_READ: begin
				// 1-based position, only entries below the count
				if (op.position >= 1 && op.position <= heap_fill) begin
					r.key = heap_model[op.position - 1];
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.count = heap_fill[COUNT_W-1:0];
		r.is_empty = (heap_fill == 0);
		r.is_full = (heap_fill == CAPACITY);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_op(input logic [OP_W-1:0] code, input logic signed [KEY_W-1:0] key,
			input logic [POS_W-1:0] pos);
		heap_op_t op;
		op.opcode = code;
		op.key = key;
		op.position = pos;
		pending_ops.push_back(op);
		if (code == OP_INSERT && shadow_fill < CAPACITY)
			shadow_fill++;
		else if (code == OP_REMOVE && shadow_fill > 0)
			shadow_fill--;
	endtask

	// mostly full-range keys, with clusters of small values for ties and the extremes
	function automatic logic signed [KEY_W-1:0] pick_key();
		int roll;
		int v;
		roll = $urandom_range(99);
		if (roll < 60)
			return $urandom;
		if (roll < 88) begin
			v = $urandom_range(16);
			v = v - 8;
			return v;
		end
		case ($urandom_range(3))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			default: return -32'sd1;
		endcase
	endfunction

	// mostly valid positions, some zero, one past the end, or anything in the field
	function automatic logic [POS_W-1:0] pick_position();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return (shadow_fill == 0) ? 9'd1 : 9'($urandom_range(shadow_fill, 1));
		if (roll < 78)
			return '0;
		if (roll < 86)
			return 9'(shadow_fill + 1);
		return 9'($urandom_range(511, 0));
	endfunction

	// random operations drifting the heap size toward a target
	task automatic add_random_ops(input int n, input int target);
		int              roll;
		logic [OP_W-1:0] code;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 2)
				code = OP_UNUSED;
			else if (roll < 12)
				code = OP_READ;
			else if ((shadow_fill < target) == ($urandom_range(99) < 90))
				code = OP_INSERT;
			else
				code = OP_REMOVE;
			queue_op(code, pick_key(), pick_position());
		end
	endtask

	// sender holds off until every word sent has come back, then a short settle
	task automatic wait_drained();
		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// driver: offers queued words, predicts each accepted one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// word taken at this edge: work out its answer
			if (in_valid && in_ready)
				expected_results.push_back(apply_heap_op(driven_op));
			// slot is free after this edge when nothing is held or the held word went in
			if (!in_valid || in_ready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					driven_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					opcode <= driven_op.opcode;
					key_in <= driven_op.key;
					position <= driven_op.position;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: random back-pressure, compares each result word
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		heap_result_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: ok %0b key_out %0d count %0d",
						ok, key_out, count);
					mismatch_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (ok !== exp_r.ok) begin
						$error("ok expected %0b got %0b", exp_r.ok, ok);
						mismatch_count++;
					end
					if (key_out !== exp_r.key) begin
						$error("key_out expected %0d got %0d", exp_r.key, key_out);
						mismatch_count++;
					end
					if (count !== exp_r.count) begin
						$error("count expected %0d got %0d", exp_r.count, count);
						mismatch_count++;
					end
					if (is_empty !== exp_r.is_empty) begin
						$error("is_empty expected %0b got %0b", exp_r.is_empty, is_empty);
						mismatch_count++;
					end
					if (is_full !== exp_r.is_full) begin
						$error("is_full expected %0b got %0b", exp_r.is_full, is_full);
						mismatch_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any word moving means the block hung
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// sequence of the run
	// ------------------------------------------------------------------
	initial begin : run
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty heap corner cases
		queue_op(OP_READ, '0, 9'd0);
		queue_op(OP_READ, '0, 9'd1);
		queue_op(OP_REMOVE, '0, '0);
		queue_op(OP_UNUSED, -32'sd1, 9'd511);
		// extremes and ties of the key
		queue_op(OP_INSERT, '0, '0);
		queue_op(OP_INSERT, 32'sh7fff_ffff, '0);
		queue_op(OP_INSERT, 32'sh8000_0000, '0);
		queue_op(OP_INSERT, -32'sd1, '0);
		queue_op(OP_INSERT, 32'sd1, '0);
		queue_op(OP_INSERT, 32'sh7fff_ffff, '0);
		queue_op(OP_INSERT, -32'sd1, '0);
		// reads: first, middle, last, one past the end, far out of range
		queue_op(OP_READ, '0, 9'd1);
		queue_op(OP_READ, '0, 9'd4);
		queue_op(OP_READ, '0, 9'd7);
		queue_op(OP_READ, '0, 9'd8);
		queue_op(OP_READ, '0, 9'd511);
		queue_op(OP_READ, '0, 9'd256);
		// drain in order, then one remove past empty
		repeat (8) queue_op(OP_REMOVE, '0, '0);
		wait_drained();

		// no idling: fill to capacity and knock on the full heap
		add_random_ops(390, CAPACITY);
		wait_drained();

		// sender idle half the time: stay near full, then come down
		sender_idle_pct <= 50;
		add_random_ops(100, CAPACITY);
		add_random_ops(220, 96);
		wait_drained();

		// receiver stalling half the time: drain to empty and keep pulling
		sender_idle_pct <= 0;
		sink_stall_pct <= 50;
		add_random_ops(200, 0);
		wait_drained();

		// both sides idling: small heaps, shallow sifts
		sender_idle_pct <= 18;
		sink_stall_pct <= 18;
		add_random_ops(300, 12);
		wait_drained();

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_seq.sv
rtl/max_heap_priority_queue_unit.sv
tb/max_heap_priority_queue_unit_test.sv
